// ===== sv/dead_reckoning_odometry_defines.svh =====
// assertion macros for the dead reckoning odometry block
`ifndef DEAD_RECKONING_ODOMETRY_DEFINES_SVH
`define DEAD_RECKONING_ODOMETRY_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DRO_ASSERT_IMP(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("odometry assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DRO_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("odometry assertion failed");

`endif

// ===== sv/dro_pkg.sv =====
// shared types, widths and tables for the dead reckoning odometry block
`timescale 1ns / 1ps
package dro_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 24;

  localparam int ATAN_LEN = 24;
  localparam int ITER_W   = $clog2(ATAN_LEN);
  localparam int CV_W     = 33;
  localparam int Z_W      = 34;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int DIST_W   = 46;
  localparam int LO_W     = 23;
  localparam int HI_W     = DIST_W - LO_W;
  localparam int COEF_W   = CV_W - 12;
  localparam int ACC_W    = 68;
  localparam int STEP_W   = ACC_W - 22;
  localparam int POS_W    = 48;
  localparam int STAMP_W  = 32;
  localparam int SPEED_W  = 24;
  localparam int RATE_W   = 32;
  localparam int HEAD_W   = 24;
  localparam int QUAT_W   = 16;
  localparam int IN_W     = STAMP_W + SPEED_W + RATE_W;
  localparam int OUT_W    = STAMP_W + 2 * POS_W + HEAD_W + 2 * QUAT_W + SPEED_W + RATE_W;

  localparam logic [CV_W-1:0] CORDIC_GAIN = CV_W'(652032874);

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic            done;
    logic [CV_W-1:0] cos_v;
    logic [CV_W-1:0] sin_v;
  } cordic_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_YAW,
    ST_MUL_DIST,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_MXL,
    ST_MXH,
    ST_MYL,
    ST_MYH,
    ST_POSE_Y,
    ST_Q_WAIT,
    ST_EMIT
  } dro_state_t;

endpackage

// ===== sv/dro_mult.sv =====
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module dro_mult (
  input  logic                               clk,
  input  logic signed [dro_pkg::MUL_W-1:0]   op_a,
  input  logic signed [dro_pkg::MUL_W-1:0]   op_b,
  output logic signed [dro_pkg::PROD_W-1:0]  product_r
);
  import dro_pkg::*;

  logic signed [PROD_W-1:0] product_nxt;

  assign product_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    product_r <= product_nxt;
  end

endmodule

// ===== sv/dro_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
`timescale 1ns / 1ps
module dro_cordic #(
  parameter int CORDIC_STEPS = dro_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dro_pkg::cordic_req_t  req,
  output dro_pkg::cordic_rsp_t  rsp
);
  import dro_pkg::*;

  logic                   busy_r;
  logic                   busy_nxt;
  logic                   done_r;
  logic                   done_nxt;
  logic                   flip_r;
  logic [ITER_W-1:0]      iter_r;
  logic signed [CV_W-1:0] x_r;
  logic signed [CV_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [31:0]            quad;
  logic                   flip;
  logic [31:0]            ang_fold;
  logic signed [CV_W-1:0] dx;
  logic signed [CV_W-1:0] dy;
  logic signed [Z_W-1:0]  atan_s;
  logic                   last;

  assign quad     = req.angle + 32'h4000_0000;
  assign flip     = quad[31];
  assign ang_fold = flip ? req.angle + 32'h8000_0000 : req.angle;
  assign dx       = y_r >>> iter_r;
  assign dy       = x_r >>> iter_r;
  assign atan_s   = Z_W'(ATAN_TAB[iter_r]);
  assign last     = (iter_r == ITER_W'(CORDIC_STEPS - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && last) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (req.start) begin
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      flip_r <= flip;
      x_r    <= $signed(CORDIC_GAIN);
      y_r    <= '0;
      z_r    <= Z_W'($signed(ang_fold));
    end else if (busy_r) begin
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_s;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_s;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = flip_r ? -x_r : x_r;
  assign rsp.sin_v = flip_r ? -y_r : y_r;

endmodule

// ===== sv/dead_reckoning_odometry.sv =====
// top level: planar dead reckoning odometry with sequencer and datapath
`timescale 1ns / 1ps
`include "dead_reckoning_odometry_defines.svh"
// Each velocity sample (timestamp, forward speed, yaw rate) advances the heading by
// rate*dt and then the position by speed*dt along cos/sin of the new heading; the
// result carries the pose, the yaw quaternion and the echoed twist. Each item makes
// two passes through the shared cordic unit, one micro-rotation per cycle, and six
// products through the single 33x33 multiplier. in_tready is high only while the
// sequencer is idle; a finished result waits in the output register while the next
// item is accepted and worked on.
module dead_reckoning_odometry #(
  parameter int CORDIC_STEPS = dro_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = dro_pkg::ANGLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // timestamp, linear_velocity, angular_velocity
  input  logic [dro_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // stamp_out, x_position, y_position, heading, quat_z, quat_w, speed_echo, rate_echo
  output logic [dro_pkg::OUT_W-1:0]  out_tdata
);
  import dro_pkg::*;

  dro_state_t                state_r;
  dro_state_t                state_nxt;
  logic                      seen_first_r;
  logic [STAMP_W-1:0]        prev_stamp_r;
  logic [STAMP_W-1:0]        stamp_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic signed [RATE_W-1:0]  rate_r;
  logic signed [31:0]        dt_r;
  logic [ANGLE_BITS-1:0]     yaw_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic signed [COEF_W-1:0]  c_r;
  logic signed [COEF_W-1:0]  s_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [POS_W-1:0]   x_r;
  logic signed [POS_W-1:0]   y_r;
  logic [QUAT_W-1:0]         qz_r;
  logic [QUAT_W-1:0]         qw_r;
  logic                      out_tvalid_r;
  logic [OUT_W-1:0]          out_tdata_r;

  logic                      accept;
  logic                      emit;
  logic [STAMP_W-1:0]        in_stamp;
  logic signed [31:0]        dt_nxt;
  logic [31:0]               ang32;
  logic signed [MUL_W-1:0]   op_a;
  logic signed [MUL_W-1:0]   op_b;
  logic signed [PROD_W-1:0]  product_r;
  logic signed [MUL_W-1:0]   lo_op;
  logic signed [MUL_W-1:0]   hi_op;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [STEP_W-1:0]  pos_step;
  cordic_req_t               cordic_req;
  cordic_rsp_t               cordic_rsp;

  function automatic logic signed [POS_W-1:0] sat_pos(
    input logic signed [POS_W-1:0]  p,
    input logic signed [STEP_W-1:0] st
  );
    logic signed [POS_W:0] sum;
    sum = (POS_W+1)'(p) + (POS_W+1)'(st);
    if (sum[POS_W] != sum[POS_W-1]) begin
      sat_pos = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_pos = sum[POS_W-1:0];
    end
  endfunction

  function automatic logic [QUAT_W-1:0] sat_q15(input logic signed [CV_W-1:0] v);
    logic signed [CV_W-16:0] q;
    q = v[CV_W-1:15];
    if (q > (CV_W-15)'(32767)) begin
      sat_q15 = 16'h7fff;
    end else if (q < -(CV_W-15)'(32768)) begin
      sat_q15 = 16'h8000;
    end else begin
      sat_q15 = q[QUAT_W-1:0];
    end
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign emit      = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign in_stamp  = in_tdata[STAMP_W-1:0];
  assign dt_nxt    = seen_first_r ? $signed(in_stamp - prev_stamp_r) : '0;
  assign ang32     = 32'(yaw_r) << (32 - ANGLE_BITS);
  assign lo_op     = MUL_W'({1'b0, dist_r[LO_W-1:0]});
  assign hi_op     = MUL_W'($signed(dist_r[DIST_W-1:LO_W]));
  assign acc_sum   = acc_r + (ACC_W'(product_r) <<< LO_W);
  assign pos_step  = acc_sum[ACC_W-1:22];
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  dro_mult u_mult (
    .clk       (clk),
    .op_a      (op_a),
    .op_b      (op_b),
    .product_r (product_r)
  );

  dro_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cordic_req),
    .rsp   (cordic_rsp)
  );

  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    op_a             = MUL_W'(rate_r);
    op_b             = MUL_W'(dt_r);
    cordic_req.start = 1'b0;
    cordic_req.angle = ang32;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_MUL_YAW;
      end
      ST_MUL_YAW: begin
        state_nxt = ST_MUL_DIST;
      end
      ST_MUL_DIST: begin
        op_a      = MUL_W'(speed_r);
        state_nxt = ST_ROT_START;
      end
      ST_ROT_START: begin
        cordic_req.start = 1'b1;
        state_nxt        = ST_ROT_WAIT;
      end
      ST_ROT_WAIT: begin
        if (cordic_rsp.done) state_nxt = ST_MXL;
      end
      ST_MXL: begin
        op_a      = lo_op;
        op_b      = MUL_W'(c_r);
        state_nxt = ST_MXH;
      end
      ST_MXH: begin
        op_a      = hi_op;
        op_b      = MUL_W'(c_r);
        state_nxt = ST_MYL;
      end
      ST_MYL: begin
        op_a      = lo_op;
        op_b      = MUL_W'(s_r);
        state_nxt = ST_MYH;
      end
      ST_MYH: begin
        op_a      = hi_op;
        op_b      = MUL_W'(s_r);
        state_nxt = ST_POSE_Y;
      end
      ST_POSE_Y: begin
        cordic_req.start = 1'b1;
        cordic_req.angle = ang32 >> 1;
        state_nxt        = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (cordic_rsp.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seen_first_r <= 1'b0;
      prev_stamp_r <= '0;
      yaw_r        <= '0;
      x_r          <= '0;
      y_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        seen_first_r <= 1'b1;
        prev_stamp_r <= in_stamp;
      end
      if (state_r == ST_MUL_DIST) begin
        yaw_r <= yaw_r + product_r[44-ANGLE_BITS +: ANGLE_BITS];
      end
      if (state_r == ST_MYL) begin
        x_r <= sat_pos(x_r, pos_step);
      end
      if (state_r == ST_POSE_Y) begin
        y_r <= sat_pos(y_r, pos_step);
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stamp_r <= in_stamp;
      speed_r <= $signed(in_tdata[STAMP_W +: SPEED_W]);
      rate_r  <= $signed(in_tdata[STAMP_W+SPEED_W +: RATE_W]);
      dt_r    <= dt_nxt;
    end
    if (state_r == ST_ROT_START) begin
      dist_r <= product_r[DIST_W+9:10];
    end
    if (state_r == ST_ROT_WAIT && cordic_rsp.done) begin
      c_r <= cordic_rsp.cos_v[CV_W-1:12];
      s_r <= cordic_rsp.sin_v[CV_W-1:12];
    end
    if (state_r == ST_MXH || state_r == ST_POSE_Y) begin
      acc_r <= ACC_W'(product_r);
    end
    if (state_r == ST_MYH) begin
      acc_r <= ACC_W'(product_r);
    end
    if (state_r == ST_Q_WAIT && cordic_rsp.done) begin
      qz_r <= sat_q15($signed(cordic_rsp.sin_v));
      qw_r <= sat_q15($signed(cordic_rsp.cos_v));
    end
    if (emit) begin
      out_tdata_r <= {rate_r, speed_r, qw_r, qz_r, ang32[31:32-HEAD_W], y_r, x_r, stamp_r};
    end
  end

  `DRO_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `DRO_ASSERT_IMP(a_rot_done_in_wait, cordic_rsp.done, state_r == ST_ROT_WAIT || state_r == ST_Q_WAIT)
  `DRO_ASSERT_NEXT(a_first_dt_zero, in_tvalid && in_tready && !seen_first_r, dt_r == '0)

endmodule

// ===== dv/tb.sv =====
// testbench for the dead reckoning odometry block: pose prediction, stimulus and checking
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic signed [31:0] rate_echo;
    logic signed [23:0] speed_echo;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic [23:0]        heading;
    logic signed [47:0] y_position;
    logic signed [47:0] x_position;
    logic [31:0]        stamp_out;
  } pose_msg_t;

  class pose_tracker;
    localparam int ANG_B = dro_pkg::ANGLE_BITS_DEF;
    localparam int STEPS = dro_pkg::CORDIC_STEPS_DEF;
    localparam longint POS_HI = 64'sh0000_7fff_ffff_ffff;
    localparam longint POS_LO = -64'sh0000_8000_0000_0000;

    longint          pos_x;
    longint          pos_y;
    bit [ANG_B-1:0]  yaw_ang;
    bit [31:0]       last_stamp;
    bit              have_stamp;
    pose_msg_t       pending_poses[$];
    int              mismatches;
    int              n_results;

    function new();
      pos_x = 0;
      pos_y = 0;
      yaw_ang = '0;
      last_stamp = '0;
      have_stamp = 1'b0;
      mismatches = 0;
      n_results = 0;
    endfunction

    // cos and sin of a 32 bit binary angle, scaled by 2^30
    function automatic void spin(input bit [31:0] ang, output longint c, output longint s);
      bit [31:0] a;
      bit        flip;
      longint    x, y, z, dx, dy;
      int        i;
      a = ang;
      flip = 1'b0;
      x = longint'(dro_pkg::CORDIC_GAIN);
      y = 0;
      if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
        flip = 1'b1;
        a = a + 32'h8000_0000;
      end
      z = longint'($signed(a));
      for (i = 0; i < STEPS && i < dro_pkg::ATAN_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(dro_pkg::ATAN_TAB[i]);
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(dro_pkg::ATAN_TAB[i]);
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = x;
      s = y;
    endfunction

    function automatic longint clamp_pos(input longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
    endfunction

    function automatic logic [15:0] clamp_q15(input longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void take_sample(input bit [31:0] stamp, input logic [23:0] speed,
                              input logic [31:0] rate);
      pose_msg_t want;
      bit [31:0] diff;
      bit [31:0] ang32;
      longint    dt, travel, turn_step, c, s;
      dt = 0;
      if (have_stamp) begin
        diff = stamp - last_stamp;
        dt = longint'($signed(diff));
      end
      have_stamp = 1'b1;
      last_stamp = stamp;

      turn_step = (longint'($signed(rate)) * dt) >>> (44 - ANG_B);
      yaw_ang = yaw_ang + turn_step[ANG_B-1:0];
      ang32 = 32'(yaw_ang) << (32 - ANG_B);

      travel = (longint'($signed(speed)) * dt) >>> 10;
      spin(ang32, c, s);
      c = c >>> 12;
      s = s >>> 12;
      pos_x = clamp_pos(pos_x + ((travel * c) >>> 22));
      pos_y = clamp_pos(pos_y + ((travel * s) >>> 22));

      want.stamp_out = stamp;
      want.x_position = pos_x[47:0];
      want.y_position = pos_y[47:0];
      want.heading = ang32[31:8];
      spin(ang32 >> 1, c, s);
      want.quat_z = clamp_q15(s >>> 15);
      want.quat_w = clamp_q15(c >>> 15);
      want.speed_echo = speed;
      want.rate_echo = rate;
      pending_poses.push_back(want);
    endfunction

    task flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_field(input string name, input logic [47:0] got, input logic [47:0] want);
      if (got !== want)
        flag_mismatch($sformatf("item %0d %s got %h want %h", n_results, name, got, want));
    endtask

    task check_pose(input pose_msg_t got);
      pose_msg_t want;
      if (pending_poses.size() == 0) begin
        flag_mismatch("pose item with no sample waiting");
        return;
      end
      want = pending_poses.pop_front();
      check_field("stamp_out", 48'(got.stamp_out), 48'(want.stamp_out));
      check_field("x_position", got.x_position, want.x_position);
      check_field("y_position", got.y_position, want.y_position);
      check_field("heading", 48'(got.heading), 48'(want.heading));
      check_field("quat_z", 48'(got.quat_z), 48'(want.quat_z));
      check_field("quat_w", 48'(got.quat_w), 48'(want.quat_w));
      check_field("speed_echo", 48'(got.speed_echo), 48'(want.speed_echo));
      check_field("rate_echo", 48'(got.rate_echo), 48'(want.rate_echo));
      n_results++;
    endtask
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [dro_pkg::IN_W-1:0]    in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [dro_pkg::OUT_W-1:0]   out_tdata;

  pose_tracker odo;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  bit [31:0]   stamp_now;

  dead_reckoning_odometry u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) odo.check_pose(pose_msg_t'(out_tdata));
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_sample(input bit [31:0] stamp, input logic [23:0] speed,
                             input logic [31:0] rate);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {rate, speed, stamp};
    do @(posedge clk); while (!in_tready);
    odo.take_sample(stamp, speed, rate);
    @(negedge clk);
  endtask

  task automatic step_stamp(input bit [31:0] delta, input logic [23:0] speed,
                            input logic [31:0] rate);
    stamp_now = stamp_now + delta;
    push_sample(stamp_now, speed, rate);
  endtask

  // long forward or backward steps at full speed and fixed heading drive the position into saturation
  task automatic run_push(input int count, input bit backward);
    logic [23:0] speed;
    for (int k = 0; k < count; k++) begin
      speed = backward ? 24'h800000 + 24'($urandom_range(0, 1000))
                       : 24'h7fffff - 24'($urandom_range(0, 1000));
      step_stamp(32'h7fff_0000 + 32'($urandom_range(0, 16'hffff)), speed, 32'h0);
    end
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                           input int push_len, input bit backward);
    int sent;
    int seg;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    if (push_len > 0) begin
      run_push(push_len, backward);
      sent = push_len;
    end
    while (sent < items) begin
      if ($urandom_range(99) < 85) begin
        seg = $urandom_range(5, 40);
        for (int k = 0; k < seg; k++) begin
          if ($urandom_range(19) == 0)
            step_stamp(-32'($urandom_range(1, 100000)), 24'($urandom), $urandom);
          else
            step_stamp(32'($urandom_range(0, 100000)), 24'($urandom), $urandom);
        end
      end else begin
        seg = $urandom_range(1, 5);
        for (int k = 0; k < seg; k++) begin
          stamp_now = $urandom;
          push_sample(stamp_now, 24'($urandom), $urandom);
        end
      end
      sent += seg;
    end
  endtask

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    odo = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed samples
    stamp_now = 32'h0000_1000;
    push_sample(stamp_now, 24'd1000, 32'd1000);
    step_stamp(32'h0010_0000, 24'h7fffff, 32'h0);
    step_stamp(32'h0010_0000, 24'h800000, 32'h7fff_ffff);
    step_stamp(32'h0010_0000, 24'h000400, 32'h0080_0000);
    step_stamp(32'h0010_0000, 24'h000400, 32'h0040_0000);
    step_stamp(32'h0010_0000, 24'h7fffff, 32'h8000_0000);
    step_stamp(-32'd5000, 24'h123456, 32'h0100_0000);
    stamp_now = 32'hffff_ff00;
    push_sample(stamp_now, 24'h000100, 32'h0);
    stamp_now = 32'h0000_0100;
    push_sample(stamp_now, 24'h7fffff, 32'h0001_0000);
    step_stamp(32'h7fff_ffff, 24'h7fffff, 32'h7fff_ffff);
    step_stamp(32'h8000_0000, 24'h800000, 32'h8000_0000);
    step_stamp(32'h8000_0000, 24'h7fffff, 32'h7fff_ffff);
    step_stamp(32'h0, 24'h800000, 32'h8000_0000);
    stamp_now = 32'hffff_ffff;
    push_sample(stamp_now, 24'h000000, 32'h0);
    stamp_now = 32'h0;
    push_sample(stamp_now, 24'hffffff, 32'hffff_ffff);

    run_phase(375, 0, 0, 0, 1'b0);
    run_phase(375, 62, 0, 200, 1'b0);
    run_phase(375, 0, 62, 0, 1'b0);
    run_phase(375, 28, 28, 200, 1'b1);

    in_tvalid <= 1'b0;
    while (odo.pending_poses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (odo.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
